// ----- hw/rtl/bsc_pkg.sv -----
package bsc_pkg;

	localparam int unsigned RawW   = 24;
	localparam int unsigned TempW  = 16;
	localparam int unsigned CalTW  = 40;
	localparam int unsigned CalPW  = 64;
	localparam int unsigned CalIdxW = 2;
	localparam int unsigned Stages = 10;

	typedef enum logic [CalIdxW-1:0] {
		CAL_TEMPERATURE = 2'd0,
		CAL_PRESSURE_A  = 2'd1,
		CAL_PRESSURE_B  = 2'd2
	} cal_idx_t;

	typedef struct packed {
		logic [RawW-1:0] raw_temperature;
		logic [RawW-1:0] raw_pressure;
	} sample_t;

	typedef struct packed {
		logic signed [TempW-1:0] temperature;
		logic [RawW-1:0]         pressure;
	} result_t;

endpackage

// ----- hw/rtl/baro_sensor_compensation.sv -----
// Channel   Dir  Handshake                      Beat
// sample    in   sample_valid / sample_ready    raw temperature, raw pressure
// result    out  result_valid / result_ready    temperature (1/256 degC), pressure (1/64 Pa)
// cal       in   cal_we (no wait)               cal_index, cal_data
//
// Ten register stages, one beat per cycle while the result is not stalled.
// Latency is set by the chain temperature -> Q20 cube -> sensitivity multiply.
// A stalled result freezes the whole pipe; sample_ready drops only then.
// Reset clears stage valids and calibration; no clearing pass.
module baro_sensor_compensation (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_ready,
	input  bsc_pkg::sample_t                      sample,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output bsc_pkg::result_t                      result,
	input  logic                                  cal_we,
	input  logic [bsc_pkg::CalIdxW-1:0]           cal_index,
	input  logic [bsc_pkg::CalPW-1:0]             cal_data
);
	import bsc_pkg::*;

	logic [CalTW-1:0] cal_t_q;
	logic [CalPW-1:0] cal_a_q, cal_b_q;
	logic             en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t_q <= '0;
			cal_a_q <= '0;
			cal_b_q <= '0;
		end else if (cal_we) begin
			unique case (cal_idx_t'(cal_index))
				CAL_TEMPERATURE: cal_t_q <= cal_data[CalTW-1:0];
				CAL_PRESSURE_A:  cal_a_q <= cal_data;
				CAL_PRESSURE_B:  cal_b_q <= cal_data;
				default: ;
			endcase
		end
	end

	assign en           = !result_valid || result_ready;
	assign sample_ready = en;

	bsc_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (sample_valid),
		.in_data  (sample),
		.cal_t    (cal_t_q),
		.cal_a    (cal_a_q),
		.cal_b    (cal_b_q),
		.out_vld  (result_valid),
		.out_data (result)
	);

endmodule

// ----- hw/rtl/bsc_datapath.sv -----
module bsc_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  bsc_pkg::sample_t           in_data,
	input  logic [bsc_pkg::CalTW-1:0]  cal_t,
	input  logic [bsc_pkg::CalPW-1:0]  cal_a,
	input  logic [bsc_pkg::CalPW-1:0]  cal_b,
	output logic                       out_vld,
	output bsc_pkg::result_t           out_data
);
	import bsc_pkg::*;

	// decoded coefficients; the user must keep them static while items are in flight, the block does not enforce it
	logic signed [16:0] t1, t2, p1, p2, p5, p6;
	logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
	logic signed [15:0] p9;

	assign t1  = {1'b0, cal_t[15:0]};
	assign t2  = {1'b0, cal_t[31:16]};
	assign t3  = cal_t[39:32];
	assign p1  = {cal_a[15], cal_a[15:0]} - 17'sd16384;
	assign p2  = {cal_a[31], cal_a[31:16]} - 17'sd16384;
	assign p3  = cal_a[39:32];
	assign p4  = cal_a[47:40];
	assign p5  = {1'b0, cal_a[63:48]};
	assign p6  = {1'b0, cal_b[15:0]};
	assign p7  = cal_b[23:16];
	assign p8  = cal_b[31:24];
	assign p9  = cal_b[47:32];
	assign p10 = cal_b[55:48];
	assign p11 = cal_b[63:56];

	logic [Stages-1:0] vld_q;

	logic signed [24:0] d;
	assign d = $signed({1'b0, in_data.raw_temperature}) - $signed({1'b0, t1[15:0], 8'h00});

	logic signed [41:0] dt2_s1;
	logic signed [49:0] dd_s1;
	logic [23:0]        rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7;
	logic signed [59:0] tl_s2;
	logic signed [15:0] temp_s3, temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9;
	logic signed [27:0] tq_s3, tq_s4;
	logic signed [35:0] tsq_s4;
	logic signed [44:0] p6tq_s4, p2tq_s4;
	logic signed [35:0] p10tq_s4;
	logic [47:0]        rp2_s4;
	logic signed [43:0] tcu_s5, p7tsq_s5, p3tsq_s5;
	logic signed [37:0] c_s5;
	logic signed [39:0] offa_s5, sa_s5, offb_s6, sb_s6, off_s7, s_s7, off_s8;
	logic [51:0]        rcube_s5;
	logic signed [51:0] p8tcu_s6, p4tcu_s6;
	logic signed [62:0] pc_s6;
	logic signed [60:0] cu_s6;
	logic signed [40:0] pc22_s7;
	logic signed [31:0] cu29_s7, cu_s8;
	logic signed [40:0] sens_s8;
	logic signed [35:0] sq_s8;
	logic signed [43:0] sum_s9;
	result_t            res_s10;

	// S3 rounding and clamps
	logic signed [59:0] tl_rt, tl_rq;
	logic signed [19:0] tr;
	logic signed [31:0] tqf;
	logic signed [15:0] temp_c;
	logic signed [27:0] tq_c;
	assign tl_rt = tl_s2 + (60'sd1 <<< 39);
	assign tl_rq = tl_s2 + (60'sd1 <<< 27);
	assign tr    = tl_rt[59:40];
	assign tqf   = tl_rq[59:28];

	always_comb begin
		priority if (tr > 20'sd32767) begin
			temp_c = 16'sh7fff;
		end else if (tr < -20'sd32768) begin
			temp_c = 16'sh8000;
		end else begin
			temp_c = tr[15:0];
		end
		priority if (tqf > 32'sd134217727) begin
			tq_c = 28'sh7ffffff;
		end else if (tqf < -32'sd134217728) begin
			tq_c = 28'sh8000000;
		end else begin
			tq_c = tqf[27:0];
		end
	end

	logic signed [55:0] tq_sq;
	logic signed [63:0] tsq_tq;
	logic signed [64:0] sens_p;
	logic signed [65:0] sq_p;
	assign tq_sq  = tq_s3 * tq_s3;
	assign tsq_tq = tsq_s4 * tq_s4;
	assign sens_p = $signed({1'b0, rp_s7}) * s_s7;
	assign sq_p   = $signed({1'b0, rp_s7}) * pc22_s7;

	// output rounding and saturation
	logic signed [43:0] sum_rnd;
	logic signed [33:0] pr;
	logic [23:0]        pr_c;
	assign sum_rnd = sum_s9 + 44'sd512;
	assign pr      = sum_rnd[43:10];

	always_comb begin
		priority if (pr < 34'sd0) begin
			pr_c = '0;
		end else if (pr > 34'sd16777215) begin
			pr_c = '1;
		end else begin
			pr_c = pr[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Stages-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// S1: offset and first temperature products
			dt2_s1 <= d * t2;
			dd_s1  <= d * d;
			rp_s1  <= in_data.raw_pressure;
			// S2: temperature in 2^-48 degC
			tl_s2 <= (60'(dt2_s1) <<< 18) + 60'(dd_s1) * 60'(t3);
			rp_s2 <= rp_s1;
			// S3
			temp_s3 <= temp_c;
			tq_s3   <= tq_c;
			rp_s3   <= rp_s2;
			// S4
			tsq_s4   <= tq_sq[55:20];
			p6tq_s4  <= p6 * tq_s3;
			p2tq_s4  <= p2 * tq_s3;
			p10tq_s4 <= p10 * tq_s3;
			rp2_s4   <= rp_s3 * rp_s3;
			tq_s4    <= tq_s3;
			temp_s4  <= temp_s3;
			rp_s4    <= rp_s3;
			// S5
			tcu_s5   <= tsq_tq[63:20];
			p7tsq_s5 <= p7 * tsq_s4;
			p3tsq_s5 <= p3 * tsq_s4;
			c_s5     <= (38'(p9) <<< 20) + 38'(p10tq_s4);
			offa_s5  <= (40'(p5) <<< 19) + 40'(p6tq_s4 >>> 10);
			sa_s5    <= (40'(p1) <<< 20) + 40'(p2tq_s4 >>> 9);
			rcube_s5 <= rp2_s4[47:20] * rp_s4;
			temp_s5  <= temp_s4;
			rp_s5    <= rp_s4;
			// S6
			p8tcu_s6 <= p8 * tcu_s5;
			p4tcu_s6 <= p4 * tcu_s5;
			offb_s6  <= offa_s5 + 40'(p7tsq_s5 >>> 12);
			sb_s6    <= sa_s5 + 40'(p3tsq_s5 >>> 12);
			pc_s6    <= $signed({1'b0, rp_s5}) * c_s5;
			cu_s6    <= $signed({1'b0, rcube_s5}) * p11;
			temp_s6  <= temp_s5;
			rp_s6    <= rp_s5;
			// S7
			off_s7  <= offb_s6 + 40'(p8tcu_s6 >>> 19);
			s_s7    <= sb_s6 + 40'(p4tcu_s6 >>> 17);
			pc22_s7 <= pc_s6[62:22];
			cu29_s7 <= cu_s6[60:29];
			temp_s7 <= temp_s6;
			rp_s7   <= rp_s6;
			// S8: sensitivity and square terms
			sens_s8 <= sens_p[64:24];
			sq_s8   <= sq_p[65:30];
			off_s8  <= off_s7;
			cu_s8   <= cu29_s7;
			temp_s8 <= temp_s7;
			// S9
			sum_s9  <= 44'(off_s8) + 44'(sens_s8) + 44'(sq_s8) + 44'(cu_s8);
			temp_s9 <= temp_s8;
			// S10: output register
			res_s10.temperature <= temp_s9;
			res_s10.pressure    <= pr_c;
		end
	end

	assign out_vld  = vld_q[Stages-1];
	assign out_data = res_s10;

endmodule

// ----- sim/baro_sensor_compensation_test.sv -----
`timescale 1ns / 100ps

module baro_sensor_compensation_test;
	import bsc_pkg::*;

	localparam logic [CalIdxW-1:0] CAL_SPARE = 2'd3;
	localparam int Latency = Stages + 4;

	typedef struct {
		int      cal_set;
		sample_t beat;
		bit      known;
		result_t exp;
	} row_t;

	typedef struct {
		logic [63:0] temperature_word;
		logic [63:0] pressure_a_word;
		logic [63:0] pressure_b_word;
	} cal_set_t;

	logic                clk;
	logic                arst_n;
	logic                sample_valid;
	logic                sample_ready;
	sample_t             sample;
	logic                result_valid;
	logic                result_ready;
	result_t             result;
	logic                cal_we;
	logic [CalIdxW-1:0]  cal_index;
	logic [CalPW-1:0]    cal_data;

	// calibration as the block should hold it
	logic [CalTW-1:0] cal_t_q;
	logic [CalPW-1:0] cal_pa_q;
	logic [CalPW-1:0] cal_pb_q;

	result_t compensated_q[$];
	int      fail_count;
	int      beats_in;
	int      beats_out;
	int      idle_pct;
	int      stall_pct;
	int      hold_cycles;
	bit      hold_req;

	baro_sensor_compensation u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cal_we       (cal_we),
		.cal_index    (cal_index),
		.cal_data     (cal_data)
	);

	always #6 clk = ~clk;

	function automatic result_t compensate(sample_t s);
		longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
		longint d, tl, temp, tq, tsq, tcu, p, off, sens_c, sens, c, sq, cube, cu, sum, pr;
		result_t r;
		t1  = longint'(cal_t_q[15:0]);
		t2  = longint'(cal_t_q[31:16]);
		t3  = longint'($signed(cal_t_q[39:32]));
		p1  = longint'($signed(cal_pa_q[15:0])) - 16384;
		p2  = longint'($signed(cal_pa_q[31:16])) - 16384;
		p3  = longint'($signed(cal_pa_q[39:32]));
		p4  = longint'($signed(cal_pa_q[47:40]));
		p5  = longint'(cal_pa_q[63:48]);
		p6  = longint'(cal_pb_q[15:0]);
		p7  = longint'($signed(cal_pb_q[23:16]));
		p8  = longint'($signed(cal_pb_q[31:24]));
		p9  = longint'($signed(cal_pb_q[47:32]));
		p10 = longint'($signed(cal_pb_q[55:48]));
		p11 = longint'($signed(cal_pb_q[63:56]));

		d  = longint'(s.raw_temperature) - t1 * 256;
		tl = d * t2 * 262144 + d * d * t3;
		temp = (tl + (longint'(1) <<< 39)) >>> 40;
		if (temp < -32768) temp = -32768;
		if (temp > 32767) temp = 32767;

		// Q20 temperature, clamped to +-128 degC
		tq = (tl + (longint'(1) <<< 27)) >>> 28;
		if (tq < -(longint'(1) <<< 27)) tq = -(longint'(1) <<< 27);
		if (tq > (longint'(1) <<< 27) - 1) tq = (longint'(1) <<< 27) - 1;
		tsq = (tq * tq) >>> 20;
		tcu = (tsq * tq) >>> 20;

		p      = longint'(s.raw_pressure);
		off    = p5 * 524288 + ((p6 * tq) >>> 10) + ((p7 * tsq) >>> 12) + ((p8 * tcu) >>> 19);
		sens_c = p1 * 1048576 + ((p2 * tq) >>> 9) + ((p3 * tsq) >>> 12) + ((p4 * tcu) >>> 17);
		sens   = (p * sens_c) >>> 24;
		c      = p9 * 1048576 + p10 * tq;
		sq     = (((p * c) >>> 22) * p) >>> 30;
		cube   = ((p * p) >>> 20) * p;
		cu     = (cube * p11) >>> 29;
		sum    = off + sens + sq + cu;
		pr     = (sum + 512) >>> 10;
		if (pr < 0) pr = 0;
		if (pr > 24'hFFFFFF) pr = 24'hFFFFFF;

		r.temperature = temp[15:0];
		r.pressure    = pr[23:0];
		return r;
	endfunction

	task automatic write_cal(logic [CalIdxW-1:0] idx, logic [63:0] value);
		wait (compensated_q.size() == 0);
		repeat (Latency) @(posedge clk);
		cal_we    <= 1'b1;
		cal_index <= idx;
		cal_data  <= value;
		@(posedge clk);
		cal_we <= 1'b0;
		case (idx)
			CAL_TEMPERATURE: cal_t_q = value[CalTW-1:0];
			CAL_PRESSURE_A:  cal_pa_q = value;
			CAL_PRESSURE_B:  cal_pb_q = value;
			default: ;
		endcase
	endtask

	task automatic load_cal(cal_set_t cs);
		write_cal(CAL_TEMPERATURE, cs.temperature_word);
		write_cal(CAL_PRESSURE_A, cs.pressure_a_word);
		write_cal(CAL_PRESSURE_B, cs.pressure_b_word);
	endtask

	// valid is only lowered when going idle, so back-to-back beats never toggle it
	task automatic send_sample(sample_t s, bit known, result_t exp);
		if ($urandom_range(99) < idle_pct) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (!sample_ready);
		compensated_q.push_back(known ? exp : compensate(s));
		beats_in++;
	endtask

	function automatic sample_t rand_sample();
		sample_t s;
		s.raw_temperature = 24'($urandom);
		s.raw_pressure    = 24'($urandom);
		case ($urandom_range(7))
			0: s.raw_temperature = '0;
			1: s.raw_temperature = '1;
			2: s.raw_pressure = '0;
			3: s.raw_pressure = '1;
			default: ;
		endcase
		return s;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_cycles = 300;
			end
			if (hold_cycles > 0) begin
				result_ready <= 1'b0;
				hold_cycles--;
			end else begin
				result_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (compensated_q.size() == 0) begin
				$error("result beat with nothing expected: temperature %0d pressure %0d",
					result.temperature, result.pressure);
				fail_count++;
			end else begin
				result_t e;
				e = compensated_q.pop_front();
				if (result.temperature !== e.temperature) begin
					$error("temperature: expected %0d, got %0d", e.temperature,
						result.temperature);
					fail_count++;
				end
				if (result.pressure !== e.pressure) begin
					$error("pressure: expected %0d, got %0d", e.pressure, result.pressure);
					fail_count++;
				end
				beats_out++;
			end
		end
	end

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		cal_set_t sets[4];
		row_t     rows[$];
		int       cur_set;
		int       idle_phase[4];
		int       stall_phase[4];
		cal_set_t cs;

		clk          = 1'b0;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		cal_we       = 1'b0;
		cal_index    = CAL_TEMPERATURE;
		cal_data     = '0;
		cal_t_q      = '0;
		cal_pa_q     = '0;
		cal_pb_q     = '0;
		fail_count   = 0;
		beats_in     = 0;
		beats_out    = 0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_cycles  = 0;
		hold_req     = 1'b0;

		// set 0: reset calibration; set 1: P5 at full scale;
		// set 2: hot sensor with junk above bit 39; set 3: cold extreme
		sets[0] = '{64'h0, 64'h0, 64'h0};
		sets[1] = '{64'h0, 64'hFFFF_0000_0000_0000, 64'h0};
		sets[2] = '{64'hA5A5_A57F_FFFF_0000, 64'h7F7F_4000_4000_7FFF,
			64'h7F7F_7FFF_7F7F_FFFF};
		sets[3] = '{64'h80_0000_FFFF, 64'h8080_8000_8000_0000, 64'h8080_8000_8080_0000};

		// with zero calibration the result is always zero (pressure clips low)
		rows.push_back('{0, '{24'h000000, 24'h000000}, 1, '{16'sd0, 24'd0}});
		rows.push_back('{0, '{24'hFFFFFF, 24'hFFFFFF}, 1, '{16'sd0, 24'd0}});
		rows.push_back('{0, '{24'h000000, 24'hFFFFFF}, 1, '{16'sd0, 24'd0}});
		rows.push_back('{0, '{24'hFFFFFF, 24'h000000}, 1, '{16'sd0, 24'd0}});
		rows.push_back('{0, '{24'h800000, 24'h123456}, 1, '{16'sd0, 24'd0}});
		// offset alone overflows the pressure range
		rows.push_back('{1, '{24'h000000, 24'h000000}, 1, '{16'sd0, 24'hFFFFFF}});
		rows.push_back('{1, '{24'hFFFFFF, 24'h000000}, 1, '{16'sd0, 24'hFFFFFF}});
		rows.push_back('{1, '{24'h5A5A5A, 24'h800000}, 0, '{16'sd0, 24'd0}});
		rows.push_back('{1, '{24'h000001, 24'hFFFFFF}, 0, '{16'sd0, 24'd0}});
		rows.push_back('{2, '{24'hFFFFFF, 24'h000000}, 0, '{16'sd0, 24'd0}});
		rows.push_back('{2, '{24'hFFFFFF, 24'hFFFFFF}, 0, '{16'sd0, 24'd0}});
		rows.push_back('{2, '{24'h000000, 24'hFFFFFF}, 0, '{16'sd0, 24'd0}});
		rows.push_back('{2, '{24'h000100, 24'h7FFFFF}, 0, '{16'sd0, 24'd0}});
		rows.push_back('{2, '{24'h6B0000, 24'h600000}, 0, '{16'sd0, 24'd0}});
		rows.push_back('{3, '{24'h000000, 24'h000000}, 0, '{16'sd0, 24'd0}});
		rows.push_back('{3, '{24'h000000, 24'hFFFFFF}, 0, '{16'sd0, 24'd0}});
		rows.push_back('{3, '{24'hFFFFFF, 24'hFFFFFF}, 0, '{16'sd0, 24'd0}});
		rows.push_back('{3, '{24'hFFFF00, 24'h400000}, 0, '{16'sd0, 24'd0}});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_set = 0;
		foreach (rows[i]) begin
			if (rows[i].cal_set != cur_set) begin
				sample_valid <= 1'b0;
				cur_set = rows[i].cal_set;
				load_cal(sets[cur_set]);
			end
			send_sample(rows[i].beat, rows[i].known, rows[i].exp);
		end

		// spare index must leave calibration alone
		sample_valid <= 1'b0;
		write_cal(CAL_SPARE, rand64());
		repeat (3) send_sample(rand_sample(), 1'b0, '0);

		idle_phase  = '{0, 62, 0, 29};
		stall_phase = '{0, 0, 62, 29};
		for (int ph = 0; ph < 8; ph++) begin
			sample_valid <= 1'b0;
			cs.temperature_word = rand64();
			cs.pressure_a_word  = rand64();
			cs.pressure_b_word  = rand64();
			if (ph == 1) cs = sets[2];
			if (ph == 5) cs = sets[3];
			if (ph == 6) begin
				// typical part: T1 near 27000, T2 near 19000, small T3
				cs.temperature_word = {24'h0, 8'hF9, 16'h4A00 + 16'($urandom_range(255)),
					16'h6900 + 16'($urandom_range(255))};
			end
			load_cal(cs);
			idle_pct  = idle_phase[ph % 4];
			stall_pct = stall_phase[ph % 4];
			for (int n = 0; n < 135; n++) begin
				if (ph == 2 && n == 20)
					hold_req = 1'b1;
				if (ph == 3 && n == 60) begin
					sample_valid <= 1'b0;
					wait (compensated_q.size() == 0);
				end
				send_sample(rand_sample(), 1'b0, '0);
			end
		end
		sample_valid <= 1'b0;

		wait (compensated_q.size() == 0);
		repeat (Latency * 2) @(posedge clk);

		$display("Compensation run: %0d samples sent, %0d results checked, 12 calibration sets",
			beats_in, beats_out);
		$display("incl. zero/full-scale/saturating calibration, long result stall, spare index");
		if (fail_count == 0 && compensated_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
